FILE: design/mcomp_pkg.sv
// ----------------------------------------------------------------------------
// mcomp_pkg: shared types and constants for the magnetometer compensation
// Holds the register index codes, the reset values and the decoded
// coefficient bundle that the register block hands to the datapath.
// ----------------------------------------------------------------------------
package mcomp_pkg;

  localparam int RAW_W   = 24;  // width of one raw sensor word
  localparam int MAG_W   = 21;  // signed value held in bits 23:3 of a raw word
  localparam int TEMP_W  = 22;  // temperature result width
  localparam int FIELD_W = 32;  // field result width
  localparam int A_W     = 36;  // field after offset, gain and temperature terms
  localparam int F_W     = 38;  // field after the cross-axis terms

  // Register index, taken from paddr[5:3].
  typedef enum logic [2:0] {
    REG_OTP_LOW    = 3'd0,
    REG_OTP_MID    = 3'd1,
    REG_OTP_HIGH   = 3'd2,
    REG_USER_OFF   = 3'd3,
    REG_USER_SCALE = 3'd4,
    REG_USER_EN    = 3'd5
  } reg_idx_t;

  // Soft-iron scales reset to 1.0 in Q2.14 on every axis.
  localparam logic [47:0] USER_SCALES_RESET = 48'h4000_4000_4000;

  // 23 degrees in 1/65536 degree steps, added to the raw temperature.
  localparam logic [TEMP_W-1:0] TEMP_BIAS = 22'd1507328;

  typedef logic signed [A_W-1:0] acc_t;
  typedef logic signed [F_W-1:0] fld_t;

  // Coefficients decoded from the OTP and user registers.
  typedef struct packed {
    logic signed [11:0] off_x, off_y, off_z;
    logic signed [17:0] gain_x, gain_y, gain_z;
    logic signed [7:0]  tco_x, tco_y, tco_z;
    logic signed [21:0] t0;
    logic signed [22:0] c_xy, c_yx, c_zx, c_zy;
    logic signed [15:0] uoff_x, uoff_y, uoff_z;
    logic [15:0]        usc_x, usc_y, usc_z;
    logic               ucal_en;
  } coef_t;

endpackage

FILE: design/mcomp_regs.sv
// ----------------------------------------------------------------------------
// mcomp_regs: configuration registers and coefficient decoder
// APB-style register file for the OTP and user words. The factory and user
// coefficients are decoded from it into a registered bundle.
// ----------------------------------------------------------------------------
module mcomp_regs
  import mcomp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output coef_t       coef
);

  logic [63:0] otp_low;
  logic [63:0] otp_mid;
  logic [31:0] otp_high;
  logic [47:0] user_off;
  logic [47:0] user_scale;
  logic        user_en;
  logic        wr;
  reg_idx_t    idx;

  assign wr  = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      otp_low    <= '0;
      otp_mid    <= '0;
      otp_high   <= '0;
      user_off   <= '0;
      user_scale <= USER_SCALES_RESET;
      user_en    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_OTP_LOW:    otp_low    <= pwdata;
        REG_OTP_MID:    otp_mid    <= pwdata;
        REG_OTP_HIGH:   otp_high   <= pwdata[31:0];
        REG_USER_OFF:   user_off   <= pwdata[47:0];
        REG_USER_SCALE: user_scale <= pwdata[47:0];
        REG_USER_EN:    user_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OTP_LOW:    prdata = otp_low;
      REG_OTP_MID:    prdata = otp_mid;
      REG_OTP_HIGH:   prdata = {32'd0, otp_high};
      REG_USER_OFF:   prdata = {16'd0, user_off};
      REG_USER_SCALE: prdata = {16'd0, user_scale};
      REG_USER_EN:    prdata = {63'd0, user_en};
      default:        prdata = '0;
    endcase
  end

  // Temperature offset t*65536/5 rounded to nearest. Since 65536 = 5*13107 + 1,
  // the quotient of |t|*65536 + 2 is 13107*|t| + (|t| + 2)/5, and the small
  // division is a multiply by 205/1024, exact below 1024.
  function automatic logic signed [21:0] t0_of(input logic signed [7:0] t);
    logic [7:0]  mag;
    logic [20:0] q;
    mag = t[7] ? 8'(-t) : 8'(t);
    q   = 21'(21'(mag) * 21'd13107) +
          21'(((16'(mag) + 16'd2) * 16'd205) >> 10);
    return t[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Cross-axis coefficient c*2^24/800 in Q24, rounded to nearest. With
  // 2^24 = 800*20971 + 416 the remainder part (416*|c| + 400)/800 is done as
  // a shift by 5 and a multiply by 1311/32768 for the division by 25.
  function automatic logic signed [22:0] cross_of(input logic signed [7:0] c);
    logic [7:0]  mag;
    logic [10:0] z;
    logic [21:0] q;
    mag = c[7] ? 8'(-c) : 8'(c);
    z   = 11'((22'(mag) * 22'd416 + 22'd400) >> 5);
    q   = 22'(22'(mag) * 22'd20971) + 22'((22'(z) * 22'd1311) >> 15);
    return c[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Sensitivity gain 1 + s/256 in Q16, plus a trim term.
  function automatic logic signed [17:0] gain_of(input logic signed [7:0] s,
                                                 input logic signed [17:0] trim);
    return 18'sd65536 + 18'($signed({s, 8'd0})) + trim;
  endfunction

  // The decoded bundle is refreshed every cycle; the datapath first reads it
  // in the offset removal stage, which works on the input register.
  always_ff @(posedge clk) begin
    coef.off_x   <= $signed(otp_low[27:16]);
    coef.off_y   <= $signed(otp_low[43:32]);
    coef.off_z   <= $signed(otp_low[59:48]);
    coef.gain_x  <= gain_of($signed(otp_low[63:56]), 18'sd0);
    coef.gain_y  <= gain_of($signed(otp_mid[7:0]), 18'sd66);
    coef.gain_z  <= gain_of($signed(otp_mid[15:8]), 18'sd0);
    coef.tco_x   <= $signed(otp_mid[23:16]);
    coef.tco_y   <= $signed(otp_mid[31:24]);
    coef.tco_z   <= $signed(otp_mid[39:32]);
    coef.t0      <= t0_of($signed(otp_low[7:0]));
    coef.c_xy    <= cross_of($signed(otp_high[7:0]));
    coef.c_yx    <= cross_of($signed(otp_high[15:8]));
    coef.c_zx    <= cross_of($signed(otp_high[23:16]));
    coef.c_zy    <= cross_of($signed(otp_high[31:24]));
    coef.uoff_x  <= $signed(user_off[15:0]);
    coef.uoff_y  <= $signed(user_off[31:16]);
    coef.uoff_z  <= $signed(user_off[47:32]);
    coef.usc_x   <= user_scale[15:0];
    coef.usc_y   <= user_scale[31:16];
    coef.usc_z   <= user_scale[47:32];
    coef.ucal_en <= user_en;
  end

endmodule

FILE: design/mcomp_front.sv
// ----------------------------------------------------------------------------
// mcomp_front: factory offset, sensitivity and temperature terms
// Four stages: input register, offset removal, gain and temperature
// products, rounding and sum.
// ----------------------------------------------------------------------------
module mcomp_front
  import mcomp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAW_W-1:0]  raw_x,
  input  logic [RAW_W-1:0]  raw_y,
  input  logic [RAW_W-1:0]  raw_z,
  input  logic [RAW_W-1:0]  raw_t,
  input  coef_t             coef,
  output logic              out_valid,
  input  logic              out_ready,
  output acc_t              a_x,
  output acc_t              a_y,
  output acc_t              a_z,
  output logic [TEMP_W-1:0] temp_out
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1
  logic [RAW_W-1:0] r_x, r_y, r_z, r_t;
  // Stage 2
  logic signed [21:0] d_x, d_y, d_z;
  logic signed [22:0] tdelta;
  logic [TEMP_W-1:0]  t2;
  // Stage 3
  logic signed [39:0] p_x, p_y, p_z;
  logic signed [30:0] q_x, q_y, q_z;
  logic [TEMP_W-1:0]  t3;

  logic signed [MAG_W-1:0] m_x, m_y, m_z, m_t;

  assign m_x = $signed(r_x[RAW_W-1:3]);
  assign m_y = $signed(r_y[RAW_W-1:3]);
  assign m_z = $signed(r_z[RAW_W-1:3]);
  assign m_t = $signed(r_t[RAW_W-1:3]);

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r_x <= raw_x;
      r_y <= raw_y;
      r_z <= raw_z;
      r_t <= raw_t;
    end
    if (rdy2 && v1) begin
      d_x    <= 22'(m_x) - 22'(coef.off_x);
      d_y    <= 22'(m_y) - 22'(coef.off_y);
      d_z    <= 22'(m_z) - 22'(coef.off_z);
      tdelta <= 23'(m_t) - 23'sd131072 - 23'(coef.t0);
      t2     <= TEMP_W'(m_t) + TEMP_BIAS;
    end
    if (rdy3 && v2) begin
      p_x <= d_x * coef.gain_x;
      p_y <= d_y * coef.gain_y;
      p_z <= d_z * coef.gain_z;
      q_x <= coef.tco_x * tdelta;
      q_y <= coef.tco_y * tdelta;
      q_z <= coef.tco_z * tdelta;
      t3  <= t2;
    end
    if (rdy4 && v3) begin
      // The gain product is d*gain*4096 scaled down by 2^16, i.e. d*gain/16.
      a_x      <= A_W'((p_x + 40'sd8) >>> 4) + A_W'((q_x + 31'sd16) >>> 5);
      a_y      <= A_W'((p_y + 40'sd8) >>> 4) + A_W'((q_y + 31'sd16) >>> 5);
      a_z      <= A_W'((p_z + 40'sd8) >>> 4) + A_W'((q_z + 31'sd16) >>> 5);
      temp_out <= t3;
    end
  end

endmodule

FILE: design/mcomp_cross.sv
// ----------------------------------------------------------------------------
// mcomp_cross: cross-axis correction
// Two stages: split partial products of the axis values with the Q24
// coupling coefficients, then merge, round and add.
// ----------------------------------------------------------------------------
module mcomp_cross
  import mcomp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  acc_t              a_x,
  input  acc_t              a_y,
  input  acc_t              a_z,
  input  logic [TEMP_W-1:0] temp_in,
  input  coef_t             coef,
  output logic              out_valid,
  input  logic              out_ready,
  output fld_t              f_x,
  output fld_t              f_y,
  output fld_t              f_z,
  output logic [TEMP_W-1:0] temp_out
);

  logic v1, v2;
  logic rdy1, rdy2;

  logic signed [18:0] alo_x, alo_y;
  logic signed [17:0] ahi_x, ahi_y;

  acc_t               b_x, b_y, b_z;
  logic signed [41:0] pl_xy, pl_yx, pl_zx, pl_zy;
  logic signed [40:0] ph_xy, ph_yx, ph_zx, ph_zy;
  logic [TEMP_W-1:0]  t1;

  // The x and y axis values are cut into an unsigned low part of 18 bits and a
  // signed high part so that no single multiplier is wider than 19x23.
  assign alo_x = $signed({1'b0, a_x[17:0]});
  assign alo_y = $signed({1'b0, a_y[17:0]});
  assign ahi_x = $signed(a_x[A_W-1:18]);
  assign ahi_y = $signed(a_y[A_W-1:18]);

  function automatic logic signed [34:0] term(input logic signed [40:0] ph,
                                              input logic signed [41:0] pl);
    logic signed [58:0] s;
    s = (59'(ph) <<< 18) + 59'(pl);
    return 35'((s + 59'sd8388608) >>> 24);
  endfunction

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      b_x   <= a_x;
      b_y   <= a_y;
      b_z   <= a_z;
      pl_xy <= alo_y * coef.c_xy;
      ph_xy <= ahi_y * coef.c_xy;
      pl_yx <= alo_x * coef.c_yx;
      ph_yx <= ahi_x * coef.c_yx;
      pl_zx <= alo_x * coef.c_zx;
      ph_zx <= ahi_x * coef.c_zx;
      pl_zy <= alo_y * coef.c_zy;
      ph_zy <= ahi_y * coef.c_zy;
      t1    <= temp_in;
    end
    if (rdy2 && v1) begin
      f_x      <= F_W'(b_x) + F_W'(term(ph_xy, pl_xy));
      f_y      <= F_W'(b_y) + F_W'(term(ph_yx, pl_yx));
      f_z      <= F_W'(b_z) + F_W'(term(ph_zx, pl_zx)) + F_W'(term(ph_zy, pl_zy));
      temp_out <= t1;
    end
  end

endmodule

FILE: design/mcomp_user.sv
// ----------------------------------------------------------------------------
// mcomp_user: user hard-iron and soft-iron correction, output stage
// Three stages: offset removal with split scale products, merge and round,
// then rounding to 1/1024 uT with saturation into the output register.
// ----------------------------------------------------------------------------
module mcomp_user
  import mcomp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fld_t               f_x,
  input  fld_t               f_y,
  input  fld_t               f_z,
  input  logic [TEMP_W-1:0]  temp_in,
  input  coef_t              coef,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] field_x,
  output logic [FIELD_W-1:0] field_y,
  output logic [FIELD_W-1:0] field_z,
  output logic [TEMP_W-1:0]  temperature
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic signed [38:0] g_x, g_y, g_z;

  fld_t               e_x, e_y, e_z;
  logic signed [35:0] pl_x, pl_y, pl_z;
  logic signed [37:0] ph_x, ph_y, ph_z;
  logic [TEMP_W-1:0]  t1, t2;
  logic signed [42:0] h_x, h_y, h_z;

  assign g_x = 39'(f_x) - 39'($signed({coef.uoff_x, 12'd0}));
  assign g_y = 39'(f_y) - 39'($signed({coef.uoff_y, 12'd0}));
  assign g_z = 39'(f_z) - 39'($signed({coef.uoff_z, 12'd0}));

  function automatic logic signed [35:0] lo_prod(input logic signed [38:0] g,
                                                 input logic [15:0] sc);
    return $signed({1'b0, g[17:0]}) * $signed({1'b0, sc});
  endfunction

  function automatic logic signed [37:0] hi_prod(input logic signed [38:0] g,
                                                 input logic [15:0] sc);
    return $signed(g[38:18]) * $signed({1'b0, sc});
  endfunction

  // Merge the split product and drop the 14 fraction bits of the scale.
  // Without user calibration the field passes through unchanged.
  function automatic logic signed [42:0] merge(input logic signed [37:0] ph,
                                               input logic signed [35:0] pl,
                                               input fld_t f,
                                               input logic en);
    logic signed [56:0] s;
    s = (57'(ph) <<< 18) + 57'(pl);
    return en ? 43'((s + 57'sd8192) >>> 14) : 43'(f);
  endfunction

  // Q16 to 1/1024 uT with rounding, then clamp to the signed 32-bit range.
  function automatic logic [FIELD_W-1:0] sat_out(input logic signed [42:0] h);
    logic signed [36:0] r;
    r = 37'((h + 43'sd32) >>> 6);
    if (r[36:31] == {6{r[36]}}) begin
      return r[31:0];
    end
    return r[36] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      e_x  <= f_x;
      e_y  <= f_y;
      e_z  <= f_z;
      pl_x <= lo_prod(g_x, coef.usc_x);
      pl_y <= lo_prod(g_y, coef.usc_y);
      pl_z <= lo_prod(g_z, coef.usc_z);
      ph_x <= hi_prod(g_x, coef.usc_x);
      ph_y <= hi_prod(g_y, coef.usc_y);
      ph_z <= hi_prod(g_z, coef.usc_z);
      t1   <= temp_in;
    end
    if (rdy2 && v1) begin
      h_x <= merge(ph_x, pl_x, e_x, coef.ucal_en);
      h_y <= merge(ph_y, pl_y, e_y, coef.ucal_en);
      h_z <= merge(ph_z, pl_z, e_z, coef.ucal_en);
      t2  <= t1;
    end
    if (rdy3 && v2) begin
      field_x     <= sat_out(h_x);
      field_y     <= sat_out(h_y);
      field_z     <= sat_out(h_z);
      temperature <= t2;
    end
  end

endmodule

FILE: design/magnetometer_compensation.sv
// ----------------------------------------------------------------------------
// magnetometer_compensation: factory and user compensation of magnetometer
// samples
// Takes raw three-axis magnetic and temperature words and returns the
// compensated field in 1/1024 uT and the die temperature in 1/65536 degC.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Request contents
//   s_*       in         raw_mag_x, raw_mag_y, raw_mag_z, raw_temp (24 bits each)
//   m_*       out        field_x, field_y, field_z (32 bits), temperature (22 bits)
//   APB       in/out     OTP words, user offsets, user scales, user enable
//
// The datapath is a nine-stage pipeline: an input register, offset removal,
// gain and temperature products, their sum, the cross-axis partial products,
// the cross-axis merge, the user offset and scale products, their merge, and
// the rounding and saturating output register. One request can enter every
// cycle unless a stall on m_tready has backed the pipeline up.
// Each stage holds its own valid bit and loads when it is empty or when the
// stage after it moves, so a stall on m_tready only backs up as far as the
// pipeline is full, and bubbles keep being filled while a result waits.
// Reset is synchronous, clears the valid bits and returns the configuration
// registers to their reset values; s_tready is held low while rst is high.
// There is no clearing pass after reset.
// Registers sit at byte addresses 8*i; the user must write them only while no
// request is in flight, as the block does not enforce it.
//
module magnetometer_compensation
  import mcomp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Input samples.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // raw_mag_x[23:0], raw_mag_y[47:24],
                                  // raw_mag_z[71:48], raw_temp[95:72]
  // Compensated results.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // field_x[31:0], field_y[63:32],
                                  // field_z[95:64], temperature[117:96],
                                  // zero[119:118]
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  coef_t coef;

  logic front_ready;
  logic front_valid;
  acc_t a_x, a_y, a_z;
  logic [TEMP_W-1:0] temp_a;

  logic cross_ready;
  logic cross_valid;
  fld_t f_x, f_y, f_z;
  logic [TEMP_W-1:0] temp_f;

  logic user_ready;
  logic [FIELD_W-1:0] field_x, field_y, field_z;
  logic [TEMP_W-1:0]  temperature;

  // The register file never waits.
  assign pready = 1'b1;

  // No request is taken while reset is applied.
  assign s_tready = front_ready & ~rst;

  mcomp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  // Offset, sensitivity and temperature coefficient.
  mcomp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid & ~rst),
    .in_ready  (front_ready),
    .raw_x     (s_tdata[23:0]),
    .raw_y     (s_tdata[47:24]),
    .raw_z     (s_tdata[71:48]),
    .raw_t     (s_tdata[95:72]),
    .coef      (coef),
    .out_valid (front_valid),
    .out_ready (cross_ready),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .temp_out  (temp_a)
  );

  // Cross-axis coupling.
  mcomp_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (cross_ready),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .temp_in   (temp_a),
    .coef      (coef),
    .out_valid (cross_valid),
    .out_ready (user_ready),
    .f_x       (f_x),
    .f_y       (f_y),
    .f_z       (f_z),
    .temp_out  (temp_f)
  );

  // Optional user calibration, rounding and saturation into the output
  // register.
  mcomp_user u_user (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cross_valid),
    .in_ready    (user_ready),
    .f_x         (f_x),
    .f_y         (f_y),
    .f_z         (f_z),
    .temp_in     (temp_f),
    .coef        (coef),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .field_x     (field_x),
    .field_y     (field_y),
    .field_z     (field_z),
    .temperature (temperature)
  );

  assign m_tdata = {2'b00, temperature, field_z, field_y, field_x};

endmodule
